// ===== hw/rtl/stwp_pkg.sv =====
// ----------------------------------------------------------------------------
// stwp_pkg
// Shared types, constants and code tables for the 6-bit text word packer.
// ----------------------------------------------------------------------------
package stwp_pkg;

  localparam int CHARS_PER_WORD = 5;
  localparam int GROUP_W        = 6;
  localparam int ACC_W          = 30;
  localparam int SHIFT_W        = 36;  // six groups, top one padded from 2 bits
  localparam int NUM_GROUPS     = 6;

  localparam logic [5:0] CODE_NONE    = 6'd0;
  localparam logic [5:0] CODE_NEWLINE = 6'd63;
  localparam logic [7:0] LOWER_OFFSET = 8'd96;
  localparam logic [7:0] UPPER_OFFSET = 8'd38;

  typedef struct packed {
    logic [7:0]  in_char;
    logic [31:0] in_word;
  } in_t;

  typedef struct packed {
    logic [31:0] word_out;
    logic        word_valid;
    logic [7:0]  char_out;
    logic        char_valid;
    logic        line_end;
    logic        bad_char;
    logic        last;
  } out_t;

  typedef struct packed {
    logic start;
    logic take;
  } unp_ctrl_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
  } unp_status_t;

  // character byte to 6-bit code, CODE_NONE when it has no code
  function automatic logic [5:0] code_of(input logic [7:0] c);
    logic [5:0] code;
    code = CODE_NONE;
    if (c >= 8'h61 && c <= 8'h7a) begin
      code = 6'(c - LOWER_OFFSET);
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      code = 6'(c - UPPER_OFFSET);
    end else begin
      unique case (c)
        8'h2e:   code = 6'd53;  // .
        8'h5f:   code = 6'd54;  // _
        8'h2c:   code = 6'd55;  // ,
        8'h27:   code = 6'd56;  // '
        8'h3f:   code = 6'd57;  // ?
        8'h21:   code = 6'd58;  // !
        8'h60:   code = 6'd59;  // `
        8'h2d:   code = 6'd60;  // -
        8'h23:   code = 6'd61;  // #
        8'h24:   code = 6'd62;  // $
        8'h0a:   code = CODE_NEWLINE;
        default: code = CODE_NONE;
      endcase
    end
    return code;
  endfunction

  // 6-bit code back to character byte; code 0 gives byte 0
  function automatic logic [7:0] char_of(input logic [5:0] code);
    logic [7:0] c;
    c = 8'h00;
    if (code >= 6'd1 && code <= 6'd26) begin
      c = {2'b00, code} + LOWER_OFFSET;
    end else if (code >= 6'd27 && code <= 6'd52) begin
      c = {2'b00, code} + UPPER_OFFSET;
    end else begin
      unique case (code)
        6'd53:        c = 8'h2e;
        6'd54:        c = 8'h5f;
        6'd55:        c = 8'h2c;
        6'd56:        c = 8'h27;
        6'd57:        c = 8'h3f;
        6'd58:        c = 8'h21;
        6'd59:        c = 8'h60;
        6'd60:        c = 8'h2d;
        6'd61:        c = 8'h23;
        6'd62:        c = 8'h24;
        CODE_NEWLINE: c = 8'h0a;
        default:      c = 8'h00;
      endcase
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/stwp_pack.sv =====
// ----------------------------------------------------------------------------
// stwp_pack
// Pack path: maps a character to its code and shifts it into the accumulator,
// producing a word after the configured count or after a newline, or a bad_char item for a character with no code.
// ----------------------------------------------------------------------------
module stwp_pack #(
  parameter int CHARS_PER_WORD = stwp_pkg::CHARS_PER_WORD
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  logic [7:0]     in_char,
  output logic           res_valid,
  output stwp_pkg::out_t res
);

  localparam int CNT_W = $clog2(CHARS_PER_WORD + 1);

  logic [stwp_pkg::ACC_W-1:0] acc;
  logic [stwp_pkg::ACC_W-1:0] acc_next;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;
  logic [5:0]                 code;
  logic                       bad;
  logic                       word_done;

  assign code       = stwp_pkg::code_of(in_char);
  assign bad        = (code == stwp_pkg::CODE_NONE);
  assign acc_next   = {acc[stwp_pkg::ACC_W-stwp_pkg::GROUP_W-1:0], code};
  assign count_next = count + 1'b1;
  assign word_done  = (code == stwp_pkg::CODE_NEWLINE) ||
                      (count_next >= CNT_W'(CHARS_PER_WORD));
  assign res_valid  = bad || word_done;

  always_comb begin
    res            = '0;
    res.last       = 1'b1;
    res.bad_char   = bad;
    if (!bad) begin
      res.word_out   = {2'b00, acc_next};
      res.word_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      count <= '0;
    end else if (load && !bad) begin
      if (word_done) begin
        acc   <= '0;
        count <= '0;
      end else begin
        acc   <= acc_next;
        count <= count_next;
      end
    end
  end

endmodule

// ===== hw/rtl/stwp_unpack.sv =====
// ----------------------------------------------------------------------------
// stwp_unpack
// Unpack sequencer: one 6-bit left shift per cycle, first to skip leading
// zero groups, then to emit one character per group, held while take is low.
// ----------------------------------------------------------------------------
module stwp_unpack (
  input  logic                  clk,
  input  logic                  rst,
  input  stwp_pkg::unp_ctrl_t   ctrl,
  input  logic [31:0]           in_word,
  output stwp_pkg::unp_status_t status,
  output stwp_pkg::out_t        res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_NORM = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam int SW = stwp_pkg::SHIFT_W;
  localparam int GW = stwp_pkg::GROUP_W;

  logic [1:0]    state;
  logic [SW-1:0] shreg;
  logic [SW-1:0] shreg_next;
  logic [2:0]    groups_left;
  logic [5:0]    top_grp;
  logic [5:0]    next_grp;
  logic          nl_follows;
  logic          final_grp;

  assign top_grp    = shreg[SW-1 -: GW];
  assign next_grp   = shreg[SW-GW-1 -: GW];
  assign shreg_next = {shreg[SW-GW-1:0], {GW{1'b0}}};

  // a trailing newline group rides on the character before it
  assign nl_follows = (groups_left == 3'd2) && (next_grp == stwp_pkg::CODE_NEWLINE);
  assign final_grp  = (groups_left == 3'd1) || nl_follows;

  assign status.busy      = (state != ST_IDLE);
  assign status.res_valid = (state == ST_EMIT);

  always_comb begin
    res          = '0;
    res.last     = final_grp;
    res.line_end = nl_follows;
    if (groups_left == 3'd1 && top_grp == stwp_pkg::CODE_NEWLINE) begin
      res.line_end = 1'b1;  // newline-only word
    end else begin
      res.char_out   = stwp_pkg::char_of(top_grp);
      res.char_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      shreg       <= '0;
      groups_left <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (ctrl.start) begin
            shreg       <= {{(SW-32){1'b0}}, in_word};
            groups_left <= 3'(stwp_pkg::NUM_GROUPS);
            state       <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (shreg == '0) begin
            groups_left <= '0;
            state       <= ST_IDLE;
          end else if (top_grp != 6'd0) begin
            state <= ST_EMIT;
          end else begin
            shreg       <= shreg_next;
            groups_left <= groups_left - 3'd1;
          end
        end
        ST_EMIT: begin
          if (ctrl.take) begin
            if (final_grp) begin
              shreg       <= '0;
              groups_left <= '0;
              state       <= ST_IDLE;
            end else begin
              shreg       <= shreg_next;
              groups_left <= groups_left - 3'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sixbit_text_word_packer_core.sv =====
// Pack: one character item per cycle unless the output stalls; a finished
//   word or a bad_char item enters the output register as its character is accepted.
// Unpack: busy after a word is accepted, while its leading zero groups are
//   skipped and its results emitted (a zero word gives none); no new word is
//   taken while busy, and output stalls hold the sequencer.
// Reset clears direction, the pack accumulator and count, and the sequencer.
// ----------------------------------------------------------------------------
// sixbit_text_word_packer_core
// 6-bit text packer and unpacker with a single output register.
// ----------------------------------------------------------------------------
module sixbit_text_word_packer_core #(
  parameter int CHARS_PER_WORD = stwp_pkg::CHARS_PER_WORD
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic           cfg_data,
  input  logic           in_valid,
  output logic           in_stall,
  input  stwp_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output stwp_pkg::out_t out_item
);

  logic                  direction;
  logic                  out_free;
  logic                  accept;
  logic                  pack_load;
  logic                  pack_res_valid;
  stwp_pkg::out_t        pack_res;
  stwp_pkg::unp_ctrl_t   unp_ctrl;
  stwp_pkg::unp_status_t unp_status;
  stwp_pkg::out_t        unp_res;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = unp_status.busy || !out_free;
  assign accept    = in_valid && !in_stall;
  assign pack_load = accept && !direction;

  assign unp_ctrl.start = accept && direction;
  assign unp_ctrl.take  = out_free;

  stwp_pack #(
    .CHARS_PER_WORD(CHARS_PER_WORD)
  ) u_pack (
    .clk      (clk),
    .rst      (rst),
    .load     (pack_load),
    .in_char  (in_item.in_char),
    .res_valid(pack_res_valid),
    .res      (pack_res)
  );

  stwp_unpack u_unpack (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (unp_ctrl),
    .in_word(in_item.in_word),
    .status (unp_status),
    .res    (unp_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
    end else if (cfg_write) begin
      direction <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((pack_load && pack_res_valid) || (unp_status.res_valid && out_free)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // the unpacker only emits while busy, so the two sources never collide
  always_ff @(posedge clk) begin
    if (pack_load && pack_res_valid) begin
      out_item <= pack_res;
    end else if (unp_status.res_valid && out_free) begin
      out_item <= unp_res;
    end
  end

endmodule

// ===== test/tb_sixbit_text_word_packer_core.sv =====
// ----------------------------------------------------------------------------
// tb_sixbit_text_word_packer_core
// Self-checking bench for the 6-bit text packer/unpacker. Characters and words
// go in through a valid/stall port. A behavioural model in the bench predicts
// every output item, and the checker compares each one field by field.
// ----------------------------------------------------------------------------
module tb_sixbit_text_word_packer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit DIR_PACK   = 1'b0;
  localparam bit DIR_UNPACK = 1'b1;
  localparam int SETTLE_CYCLES = 20;  // covers the slowest unpack sequence
  localparam logic [5:0] FIRST_PUNCT = 6'd53;

  logic           clk;
  logic           rst;
  logic           cfg_write;
  logic           cfg_data;
  logic           in_valid;
  logic           in_stall;
  stwp_pkg::in_t  in_item;
  logic           out_valid;
  logic           out_stall;
  stwp_pkg::out_t out_item;

  sixbit_text_word_packer_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // model state
  bit             model_dir;
  logic [29:0]    packed_chars;
  logic [2:0]     packed_count;
  stwp_pkg::out_t pending_results[$];

  bit idle_on;
  bit stall_on;
  int errors;
  int items_sent;
  int results_seen;
  int dir_writes;
  int words_packed;
  int chars_unpacked;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- code table
  function automatic logic [7:0] punct_byte(input int idx);
    unique case (idx)
      0:       return 8'h2e;
      1:       return 8'h5f;
      2:       return 8'h2c;
      3:       return 8'h27;
      4:       return 8'h3f;
      5:       return 8'h21;
      6:       return 8'h60;
      7:       return 8'h2d;
      8:       return 8'h23;
      9:       return 8'h24;
      default: return 8'h0a;
    endcase
  endfunction

  function automatic logic [5:0] code_for(input logic [7:0] c);
    logic [5:0] code;
    code = stwp_pkg::CODE_NONE;
    if (c >= "a" && c <= "z") begin
      code = 6'(c - 8'h60);
    end else if (c >= "A" && c <= "Z") begin
      code = 6'(c - 8'h26);
    end else begin
      for (int i = 0; i < 11; i++) begin
        if (c == punct_byte(i)) code = FIRST_PUNCT + 6'(i);
      end
    end
    return code;
  endfunction

  function automatic logic [7:0] char_for(input logic [5:0] code);
    if (code == stwp_pkg::CODE_NONE) return 8'h00;
    if (code <= 6'd26) return {2'b00, code} + 8'h60;
    if (code <= 6'd52) return {2'b00, code} + 8'h26;
    return punct_byte(int'(code - FIRST_PUNCT));
  endfunction

  // ---------------------------------------------------------------- prediction
  function automatic void predict_pack(input logic [7:0] c);
    logic [5:0]     code;
    stwp_pkg::out_t r;
    code = code_for(c);
    r = '0;
    if (code == stwp_pkg::CODE_NONE) begin
      r.bad_char = 1'b1;
      r.last     = 1'b1;
      pending_results.push_back(r);
      return;
    end
    packed_chars = {packed_chars[23:0], code};
    packed_count = packed_count + 3'd1;
    if (code == stwp_pkg::CODE_NEWLINE || packed_count >= 3'(stwp_pkg::CHARS_PER_WORD)) begin
      r.word_out   = {2'b00, packed_chars};
      r.word_valid = 1'b1;
      r.last       = 1'b1;
      pending_results.push_back(r);
      packed_chars = '0;
      packed_count = '0;
      words_packed++;
    end
  endfunction

  function automatic void predict_unpack(input logic [31:0] w);
    logic [31:0]    rest;
    logic [5:0]     code;
    stwp_pkg::out_t res[6];
    int             groups;
    int             n;
    bit             ends_line;
    rest = w;
    groups = 0;
    n = 0;
    ends_line = 1'b0;
    while (rest != 0 && groups < 6) begin
      rest = rest >> 6;
      groups++;
    end
    if (groups == 0) return;
    for (int g = groups - 1; g >= 0; g--) begin
      code = 6'(w >> (6 * g));
      if (g == 0 && code == stwp_pkg::CODE_NEWLINE) begin
        ends_line = 1'b1;
      end else begin
        res[n] = '0;
        res[n].char_out   = char_for(code);
        res[n].char_valid = 1'b1;
        n++;
      end
    end
    if (n == 0) begin
      res[0] = '0;
      n = 1;
    end
    res[n-1].line_end = ends_line;
    res[n-1].last     = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
    chars_unpacked += n;
  endfunction

  // ---------------------------------------------------------------- drivers
  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [7:0] c, input logic [31:0] w);
    while (idle_on && $urandom_range(99) < 16) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_item.in_char = c;
    in_item.in_word = w;
    do @(posedge clk); while (in_stall);
    if (model_dir == DIR_PACK) predict_pack(c);
    else predict_unpack(w);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // an item with no result may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_direction(input bit d);
    wait_for_results();
    cfg_write = 1'b1;
    cfg_data  = d;
    @(posedge clk);
    model_dir = d;
    @(negedge clk);
    cfg_write = 1'b0;
    dir_writes++;
  endtask

  always @(negedge clk) begin
    out_stall = stall_on && ($urandom_range(99) < 16);
  end

  // ---------------------------------------------------------------- checker
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_checker
    stwp_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("output item with nothing expected: 0x%0h", out_item);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("word_out",   want.word_out,          out_item.word_out);
        check_field("word_valid", 32'(want.word_valid),   32'(out_item.word_valid));
        check_field("char_out",   32'(want.char_out),     32'(out_item.char_out));
        check_field("char_valid", 32'(want.char_valid),   32'(out_item.char_valid));
        check_field("line_end",   32'(want.line_end),     32'(out_item.line_end));
        check_field("bad_char",   32'(want.bad_char),     32'(out_item.bad_char));
        check_field("last",       32'(want.last),         32'(out_item.last));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic [7:0] random_char();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 8'($urandom_range(255));  // mostly unmapped noise
    if (roll < 18) return 8'h0a;
    return char_for(6'($urandom_range(1, 63)));
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int          roll;
    int          k;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 15) return $urandom();
    k = $urandom_range(1, 5);
    w = '0;
    for (int i = 0; i < k; i++) w = (w << 6) | 32'($urandom_range(1, 63));
    if ($urandom_range(99) < 30) w = (w << 6) | 32'(stwp_pkg::CODE_NEWLINE);
    else if (k < 5) w = (w << 6) | 32'($urandom_range(0, 63));
    // sometimes fill the top two-bit group as well
    if ($urandom_range(99) < 15) w[31:30] = 2'($urandom_range(1, 3));
    return w;
  endfunction

  task automatic test_pack_directed();
    logic [7:0] chars[20];
    chars = '{"a", "z", "A", "Z", 8'h2e,
              8'h5f, 8'h2c, 8'h27, 8'h3f, 8'h21,
              8'h60, 8'h2d, 8'h23, 8'h24, 8'h0a,
              8'h00, 8'hff, 8'h0a, "q", "Q"};
    set_direction(DIR_PACK);
    // ends on a partial word, finished after the unpack test
    foreach (chars[i]) send_item(chars[i], ~32'(i));
  endtask

  task automatic test_unpack_directed();
    logic [31:0] words[5];
    words = '{32'h0000_0000, 32'h0000_003f, 32'hffff_ffff,
              32'h0000_1000, 32'h4000_0000};
    set_direction(DIR_UNPACK);
    foreach (words[i]) send_item(8'hff, words[i]);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      set_direction(phase % 2 == 0 ? DIR_PACK : DIR_UNPACK);
      idle_on  = (phase != 4);
      stall_on = (phase != 4);
      for (int i = 0; i < 17; i++) begin
        if (phase == 3 && i == 10) wait_for_results();
        send_item(random_char(), random_word());
      end
    end
    idle_on  = 1'b1;
    stall_on = 1'b1;
    set_direction(DIR_PACK);
  endtask

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_data  = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_stall = 1'b0;
    idle_on   = 1'b1;
    stall_on  = 1'b1;
    model_dir    = DIR_PACK;
    packed_chars = '0;
    packed_count = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_pack_directed();
    test_unpack_directed();
    test_random_traffic();
    wait_for_results();

    $display("Sent %0d items over %0d direction writes; checked %0d output items.",
             items_sent, dir_writes, results_seen);
    $display("Predicted %0d packed words and %0d unpack results.",
             words_packed, chars_unpacked);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timed out with %0d output items outstanding", pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sixbit_text_word_packer_core.f =====
hw/rtl/stwp_pkg.sv
hw/rtl/stwp_pack.sv
hw/rtl/stwp_unpack.sv
hw/rtl/sixbit_text_word_packer_core.sv
test/tb_sixbit_text_word_packer_core.sv
